// File: hw/rtl/set_assoc_lru_cache_tag_model_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cache tag model
// Clocked on clk and disabled during rst in the module that uses them.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_LRU_CACHE_TAG_MODEL_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_TAG_MODEL_DEFINES_SVH

// Same-cycle implication
`define SALC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define SALC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/salc_pkg.sv
// ----------------------------------------------------------------------------
// salc_pkg
// Shared types and constants of the cache tag model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package salc_pkg;

  localparam int ADDR_W = 32;
  localparam int TAG_W  = 30;   // address bits above the smallest block offset
  localparam int CNT_W  = 6;

  // access kinds
  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_STORE = 2'd1;
  localparam logic [1:0] MODE_FETCH = 2'd2;

  // register indexes
  localparam logic [2:0] REG_SPLIT  = 3'd0;
  localparam logic [2:0] REG_BLOG   = 3'd1;
  localparam logic [2:0] REG_FSETS  = 3'd2;
  localparam logic [2:0] REG_DSETS  = 3'd3;
  localparam logic [2:0] REG_WAYS   = 3'd4;
  localparam logic [2:0] REG_WBACK  = 3'd5;
  localparam logic [2:0] REG_WALLOC = 3'd6;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [1:0]        mode;
  } req_t;

  typedef struct packed {
    logic             hit;
    logic             replaced;
    logic [CNT_W-1:0] fetch_words;
    logic [CNT_W-1:0] copy_back_words;
    logic             data_side;
  } res_t;

  typedef struct packed {
    logic       split_mode;
    logic [2:0] block_bytes_log2;
    logic [3:0] first_sets_log2;
    logic [3:0] data_sets_log2;
    logic [3:0] ways;
    logic       write_back;
    logic       write_allocate;
  } cfg_t;

endpackage

// File: hw/rtl/salc_set_update.sv
// ----------------------------------------------------------------------------
// salc_set_update
// Lookup and update of one set row: hit search, fill or LRU eviction, ageing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module salc_set_update #(
  parameter int MAX_WAYS = 8,
  parameter int WIDX_W   = 3,
  parameter int RANK_W   = 3,
  parameter int FILL_W   = 4
) (
  input  salc_pkg::cfg_t                            cfg,
  input  logic [salc_pkg::TAG_W-1:0]                tag,
  input  logic [1:0]                                mode,
  input  logic [MAX_WAYS-1:0][salc_pkg::TAG_W-1:0]  tag_q,
  input  logic [MAX_WAYS-1:0]                       valid_q,
  input  logic [MAX_WAYS-1:0]                       dirty_q,
  input  logic [MAX_WAYS-1:0][RANK_W-1:0]           rank_q,
  input  logic [FILL_W-1:0]                         fill_q,
  output logic [MAX_WAYS-1:0][salc_pkg::TAG_W-1:0]  tag_d,
  output logic [MAX_WAYS-1:0]                       valid_d,
  output logic [MAX_WAYS-1:0]                       dirty_d,
  output logic [MAX_WAYS-1:0][RANK_W-1:0]           rank_d,
  output logic [FILL_W-1:0]                         fill_d,
  output salc_pkg::res_t                            res
);
  import salc_pkg::*;

  always_comb begin
    logic              found;
    logic              have_vic;
    logic [WIDX_W-1:0] fw;
    logic [WIDX_W-1:0] slot;
    logic [RANK_W-1:0] lim;
    logic [2:0]        blog;
    logic [CNT_W-1:0]  bwords;
    logic [4:0]        nways;
    logic              is_store;

    tag_d    = tag_q;
    valid_d  = valid_q;
    dirty_d  = dirty_q;
    rank_d   = rank_q;
    fill_d   = fill_q;
    res      = '0;
    found    = 1'b0;
    have_vic = 1'b0;
    fw       = '0;
    slot     = '0;
    lim      = '0;
    is_store = (mode == MODE_STORE);

    // clamp the geometry registers
    blog   = (cfg.block_bytes_log2 < 3'd2) ? 3'd2 : cfg.block_bytes_log2;
    bwords = CNT_W'(6'd1 << (blog - 3'd2));
    if (cfg.ways == 4'd0) begin
      nways = 5'd1;
    end else if (5'(cfg.ways) > 5'(MAX_WAYS)) begin
      nways = 5'(MAX_WAYS);
    end else begin
      nways = 5'(cfg.ways);
    end

    // hit search: most recent matching line wins
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (valid_q[w] && tag_q[w] == tag && (!found || rank_q[w] < rank_q[fw])) begin
        found = 1'b1;
        fw    = WIDX_W'(w);
      end
    end

    if (mode == MODE_LOAD || mode == MODE_STORE || mode == MODE_FETCH) begin
      res.data_side = (mode != MODE_FETCH);
      if (found) begin
        res.hit = 1'b1;
        if (is_store) begin
          if (cfg.write_back) begin
            dirty_d[fw] = 1'b1;
          end else begin
            res.copy_back_words = CNT_W'(1);
          end
        end
        lim = rank_q[fw];
        for (int w = 0; w < MAX_WAYS; w++) begin
          if (valid_q[w] && rank_q[w] < lim) begin
            rank_d[w] = rank_q[w] + 1'b1;
          end
        end
        rank_d[fw] = '0;
      end else if (is_store && !cfg.write_allocate) begin
        res.copy_back_words = CNT_W'(1);
      end else begin
        res.fetch_words = bwords;
        if (5'(fill_q) < nways) begin
          // fill the lowest free way, age every valid line
          for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (!valid_q[w]) begin
              slot = WIDX_W'(w);
            end
          end
          for (int w = 0; w < MAX_WAYS; w++) begin
            if (valid_q[w]) begin
              rank_d[w] = rank_q[w] + 1'b1;
            end
          end
          fill_d = fill_q + 1'b1;
        end else begin
          // evict the oldest valid line, lowest way on ties
          for (int w = 0; w < MAX_WAYS; w++) begin
            if (valid_q[w] && (!have_vic || rank_q[w] > rank_q[slot])) begin
              have_vic = 1'b1;
              slot     = WIDX_W'(w);
            end
          end
          res.replaced = 1'b1;
          if (valid_q[slot] && dirty_q[slot]) begin
            res.copy_back_words = bwords;
          end
          lim = rank_q[slot];
          for (int w = 0; w < MAX_WAYS; w++) begin
            if (valid_q[w] && rank_q[w] < lim) begin
              rank_d[w] = rank_q[w] + 1'b1;
            end
          end
        end
        valid_d[slot] = 1'b1;
        tag_d[slot]   = tag;
        rank_d[slot]  = '0;
        dirty_d[slot] = 1'b0;
        if (is_store) begin
          if (cfg.write_back) begin
            dirty_d[slot] = 1'b1;
          end else begin
            res.copy_back_words = res.copy_back_words + 1'b1;
          end
        end
      end
    end
  end

endmodule

// File: hw/rtl/set_assoc_lru_cache_tag_model.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tag_model
// Tag, valid, dirty and true-LRU model of a unified or split cache.
// ----------------------------------------------------------------------------
// One request is taken when start is high and busy is low. Its result appears
// on res with done high for exactly one cycle, registered through pend and then
// done; the receiver cannot stall it. Each request keeps busy high while it reads
// its set row from the state memory and then compares the ways and writes the row
// back, so the block takes no new request before that request is through.
// After reset, busy stays high while the state memory is cleared one row a cycle,
// all NUM_CACHES << MAX_SETS_LOG2 rows (512 at the defaults); configuration writes
// are taken throughout (cfg_ready is always high).
`timescale 1ns / 1ps

`include "set_assoc_lru_cache_tag_model_defines.svh"

module set_assoc_lru_cache_tag_model #(
  parameter int MAX_SETS_LOG2 = 8,
  parameter int MAX_WAYS      = 8,
  parameter int NUM_CACHES    = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  salc_pkg::req_t  req,
  output logic            done,
  output salc_pkg::res_t  res,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [2:0]      cfg_index,
  input  logic [3:0]      cfg_data
);
  import salc_pkg::*;

  localparam int SETS   = 1 << MAX_SETS_LOG2;
  localparam int ROWS   = NUM_CACHES * SETS;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int WIDX_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int RANK_W = WIDX_W;
  localparam int FILL_W = $clog2(MAX_WAYS + 1);
  localparam int ENT_W  = TAG_W + 2 + RANK_W;
  localparam int ROW_W  = MAX_WAYS * ENT_W + FILL_W;

  cfg_t                cfg;
  logic                pend;
  logic                clearing;
  logic [ROW_AW-1:0]   clr_cnt;
  logic [ROW_AW-1:0]   row_q;
  logic [TAG_W-1:0]    tag_q;
  logic [1:0]          mode_q;
  logic [ROW_W-1:0]    mem [ROWS];
  logic [ROW_W-1:0]    rdata;
  logic [ROW_W-1:0]    wdata;

  logic                accept;
  logic                cidx;
  logic [2:0]          blog;
  logic [3:0]          slog;
  logic [31:0]         set_idx;
  logic [ROW_AW-1:0]   row_in;
  logic [TAG_W-1:0]    tag_in;

  logic [MAX_WAYS-1:0][TAG_W-1:0]  way_tag_q, way_tag_d;
  logic [MAX_WAYS-1:0]             way_valid_q, way_valid_d;
  logic [MAX_WAYS-1:0]             way_dirty_q, way_dirty_d;
  logic [MAX_WAYS-1:0][RANK_W-1:0] way_rank_q, way_rank_d;
  logic [FILL_W-1:0]               fill_q, fill_d;
  res_t                            res_d;

  assign cfg_ready = 1'b1;
  assign busy      = pend | clearing;
  assign accept    = start & ~busy;

  // hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.split_mode       <= 1'b0;
      cfg.block_bytes_log2 <= 3'd4;
      cfg.first_sets_log2  <= 4'd6;
      cfg.data_sets_log2   <= 4'd6;
      cfg.ways             <= 4'd1;
      cfg.write_back       <= 1'b1;
      cfg.write_allocate   <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SPLIT:  cfg.split_mode       <= cfg_data[0];
        REG_BLOG:   cfg.block_bytes_log2 <= cfg_data[2:0];
        REG_FSETS:  cfg.first_sets_log2  <= cfg_data;
        REG_DSETS:  cfg.data_sets_log2   <= cfg_data;
        REG_WAYS:   cfg.ways             <= cfg_data;
        REG_WBACK:  cfg.write_back       <= cfg_data[0];
        REG_WALLOC: cfg.write_allocate   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // decode set row and tag of the incoming request
  always_comb begin
    cidx = (NUM_CACHES > 1) && cfg.split_mode && (req.mode != MODE_FETCH);
    blog = (cfg.block_bytes_log2 < 3'd2) ? 3'd2 : cfg.block_bytes_log2;
    slog = cidx ? cfg.data_sets_log2 : cfg.first_sets_log2;
    if (slog > 4'(MAX_SETS_LOG2)) begin
      slog = 4'(MAX_SETS_LOG2);
    end
    set_idx = (req.address >> blog) & ((32'd1 << slog) - 32'd1);
    row_in  = ROW_AW'(set_idx + (cidx ? 32'(SETS) : 32'd0));
    tag_in  = TAG_W'(req.address >> (5'(slog) + 5'(blog)));
  end

  // advance control: clearing pass, then the pend and done strobes of each request
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
      pend     <= 1'b0;
      done     <= 1'b0;
    end else begin
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == ROW_AW'(ROWS - 1)) begin
          clearing <= 1'b0;
        end
      end
      pend <= accept;
      done <= pend;
    end
  end

  // hold request and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      row_q  <= row_in;
      tag_q  <= tag_in;
      mode_q <= req.mode;
    end
    if (pend) begin
      res <= res_d;
    end
  end

  // set memory: one row per set, read at accept, written back the next cycle
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_cnt] <= '0;
    end else if (pend) begin
      mem[row_q] <= wdata;
    end
    rdata <= mem[row_in];
  end

  // unpack and repack the row
  for (genvar w = 0; w < MAX_WAYS; w++) begin : g_way
    assign way_tag_q[w]   = rdata[w*ENT_W +: TAG_W];
    assign way_valid_q[w] = rdata[w*ENT_W + TAG_W];
    assign way_dirty_q[w] = rdata[w*ENT_W + TAG_W + 1];
    assign way_rank_q[w]  = rdata[w*ENT_W + TAG_W + 2 +: RANK_W];
    assign wdata[w*ENT_W +: ENT_W] = {way_rank_d[w], way_dirty_d[w], way_valid_d[w],
                                      way_tag_d[w]};
  end
  assign fill_q = rdata[MAX_WAYS*ENT_W +: FILL_W];
  assign wdata[MAX_WAYS*ENT_W +: FILL_W] = fill_d;

  salc_set_update #(
    .MAX_WAYS (MAX_WAYS),
    .WIDX_W   (WIDX_W),
    .RANK_W   (RANK_W),
    .FILL_W   (FILL_W)
  ) u_update (
    .cfg     (cfg),
    .tag     (tag_q),
    .mode    (mode_q),
    .tag_q   (way_tag_q),
    .valid_q (way_valid_q),
    .dirty_q (way_dirty_q),
    .rank_q  (way_rank_q),
    .fill_q  (fill_q),
    .tag_d   (way_tag_d),
    .valid_d (way_valid_d),
    .dirty_d (way_dirty_d),
    .rank_d  (way_rank_d),
    .fill_d  (fill_d),
    .res     (res_d)
  );

  `SALC_ASSERT_NEXT(a_pend_gives_done, pend, done, "request without result strobe")
  `SALC_ASSERT_NOW(a_no_done_clearing, clearing, !done && !pend, "request during clearing")
  `SALC_ASSERT_NOW(a_hit_no_fetch, done && res.hit, !res.replaced && res.fetch_words == '0, "hit fill")
  `SALC_ASSERT_NOW(a_done_spaced, done, !pend, "results closer than two cycles")

endmodule
